>>> rtl/bcpm_pkg.sv
// ----------------------------------------------------------------------------
// bcpm_pkg
// Shared types and field widths of the balanced column partition mapper.
// ----------------------------------------------------------------------------
package bcpm_pkg;

    localparam int SCORE_W = 24;
    localparam int COL_W   = 6;
    localparam int PC_W    = 5;
    localparam int SUM_W   = 31;
    localparam int SIZE_W  = 7;

    typedef struct packed {
        logic load;
        logic drain;
    } cell_ctl_t;

endpackage

>>> rtl/bcpm_cell.sv
// ----------------------------------------------------------------------------
// bcpm_cell
// One sort cell: holds a (score, column) pair, inserts in descending order
// and shifts toward the head when the chain is drained.
// ----------------------------------------------------------------------------
module bcpm_cell
    import bcpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [SCORE_W-1:0] new_score,
    input  logic [COL_W-1:0]   new_col,
    input  logic               prev_beats,
    input  logic [SCORE_W-1:0] prev_score,
    input  logic [COL_W-1:0]   prev_col,
    input  logic               prev_valid,
    input  logic [SCORE_W-1:0] next_score,
    input  logic [COL_W-1:0]   next_col,
    input  logic               next_valid,
    output logic               beats,
    output logic [SCORE_W-1:0] score,
    output logic [COL_W-1:0]   col,
    output logic               valid
);

    logic [SCORE_W-1:0] score_reg;
    logic [COL_W-1:0]   col_reg;
    logic               valid_reg;

    assign beats = !valid_reg || (new_score > score_reg) ||
                   ((new_score == score_reg) && (new_col > col_reg));
    assign score = score_reg;
    assign col   = col_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.drain)
        begin
            valid_reg <= next_valid;
        end
        else if (ctl.load && beats)
        begin
            valid_reg <= prev_beats ? prev_valid : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.drain)
        begin
            score_reg <= next_score;
            col_reg   <= next_col;
        end
        else if (ctl.load && beats)
        begin
            score_reg <= prev_beats ? prev_score : new_score;
            col_reg   <= prev_beats ? prev_col : new_col;
        end
    end

endmodule

>>> rtl/balanced_column_partition_mapper_top.sv
// ----------------------------------------------------------------------------
// balanced_column_partition_mapper_top
// Sorts loaded columns by score, deals them to partitions in rounds and
// emits the resulting column permutation.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one (score, column) item per cycle
// while loading; each item up to MAX_COLUMNS is inserted into the chain of
// sort cells in the cycle it is taken. An item with final_column set starts
// the computation and in_stall stays high until the emission scan of the
// last partition has ended.
// Dealing: for each column, one shared comparator scans the partition
// sums, then an update step adds the column to the chosen partition.
// Emission: per partition, a selection scan, then a scan through the
// assignment memory over every loaded column.
// Output channel (out_valid / out_stall): one mapped_column per stored item,
// last_entry set on the final one. A stall holds the output register and
// halts the scan; nothing is lost. Reset empties the cell chain and sets
// the partition count to 1; the count is written through cfg_valid /
// cfg_ready / cfg_data, which is always ready.
// ----------------------------------------------------------------------------
module balanced_column_partition_mapper_top
    import bcpm_pkg::*;
#(
    parameter int MAX_COLUMNS    = 64,
    parameter int MAX_PARTITIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PC_W-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SCORE_W-1:0] score_value,
    input  logic [COL_W-1:0]   column_id,
    input  logic               final_column,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COL_W-1:0]   mapped_column,
    output logic               last_entry
);

    localparam int LC_W   = $clog2(MAX_COLUMNS + 1);
    localparam int IDX_W  = $clog2(MAX_COLUMNS);
    localparam int SLOT_W = $clog2(MAX_PARTITIONS > 1 ? MAX_PARTITIONS : 2);
    localparam int PCNT_W = $clog2(MAX_PARTITIONS + 1);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_DSEL = 3'd1;
    localparam logic [2:0] ST_DASN = 3'd2;
    localparam logic [2:0] ST_ESEL = 3'd3;
    localparam logic [2:0] ST_ERD  = 3'd4;
    localparam logic [2:0] ST_ECHK = 3'd5;

    logic [2:0]               state_reg;
    logic [PC_W-1:0]          part_reg;
    logic [LC_W-1:0]          cnt_reg;
    logic [LC_W-1:0]          idx_reg;
    logic [LC_W-1:0]          emit_cnt_reg;
    logic [IDX_W-1:0]         scan_reg;
    logic [SLOT_W-1:0]        j_reg;
    logic [PCNT_W-1:0]        round_reg;
    logic [PCNT_W-1:0]        done_reg;
    logic [SUM_W-1:0]         sum_reg [MAX_PARTITIONS];
    logic [SIZE_W-1:0]        size_reg [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] served_reg;
    logic [MAX_PARTITIONS-1:0] picked_reg;
    logic [SLOT_W-1:0]        best_slot_reg;
    logic [SUM_W-1:0]         best_sum_reg;
    logic [SIZE_W-1:0]        best_size_reg;
    logic                     best_pri_reg;
    logic                     best_valid_reg;
    logic [COL_W-1:0]         col_mem [MAX_COLUMNS];
    logic [SLOT_W-1:0]        slot_mem [MAX_COLUMNS];
    logic [COL_W-1:0]         col_rd_reg;
    logic [SLOT_W-1:0]        slot_rd_reg;
    logic                     out_valid_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic                     out_last_reg;

    logic [PCNT_W-1:0]  p_eff;
    logic               in_accept;
    logic [LC_W-1:0]    cnt_next;
    logic               j_last;
    logic               cand;
    logic               pri_j;
    logic               key_less;
    logic               match;
    logic               out_load;
    logic               out_busy;
    cell_ctl_t          ctl;

    logic [SCORE_W-1:0] c_score [MAX_COLUMNS];
    logic [COL_W-1:0]   c_col   [MAX_COLUMNS];
    logic               c_valid [MAX_COLUMNS];
    logic               c_beats [MAX_COLUMNS];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (part_reg == '0)
            p_eff = PCNT_W'(1);
        else if (32'(part_reg) > 32'(MAX_PARTITIONS))
            p_eff = PCNT_W'(MAX_PARTITIONS);
        else
            p_eff = PCNT_W'(part_reg);
    end

    assign ctl.load  = in_accept && (32'(cnt_reg) < 32'(MAX_COLUMNS));
    assign ctl.drain = (state_reg == ST_DASN);
    assign cnt_next  = ctl.load ? cnt_reg + LC_W'(1) : cnt_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_COLUMNS; g++)
        begin : g_cell
            logic               pb;
            logic [SCORE_W-1:0] ps;
            logic [COL_W-1:0]   pc;
            logic               pv;
            logic [SCORE_W-1:0] ns;
            logic [COL_W-1:0]   nc;
            logic               nv;
            if (g == 0)
            begin : g_head
                assign pb = 1'b0;
                assign ps = '0;
                assign pc = '0;
                assign pv = 1'b0;
            end
            else
            begin : g_body
                assign pb = c_beats[g-1];
                assign ps = c_score[g-1];
                assign pc = c_col[g-1];
                assign pv = c_valid[g-1];
            end
            if (g == MAX_COLUMNS - 1)
            begin : g_tail
                assign ns = '0;
                assign nc = '0;
                assign nv = 1'b0;
            end
            else
            begin : g_mid
                assign ns = c_score[g+1];
                assign nc = c_col[g+1];
                assign nv = c_valid[g+1];
            end
            bcpm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_score  (score_value),
                .new_col    (column_id),
                .prev_beats (pb),
                .prev_score (ps),
                .prev_col   (pc),
                .prev_valid (pv),
                .next_score (ns),
                .next_col   (nc),
                .next_valid (nv),
                .beats      (c_beats[g]),
                .score      (c_score[g]),
                .col        (c_col[g]),
                .valid      (c_valid[g])
            );
        end
    endgenerate

    assign j_last = (PCNT_W'(j_reg) + PCNT_W'(1)) == p_eff;
    assign cand   = !picked_reg[j_reg];
    assign pri_j  = (state_reg == ST_ESEL) ? !served_reg[j_reg] : 1'b0;

    always_comb
    begin
        if (pri_j != best_pri_reg)
            key_less = !pri_j;
        else if (sum_reg[j_reg] != best_sum_reg)
            key_less = sum_reg[j_reg] < best_sum_reg;
        else
            key_less = size_reg[j_reg] < best_size_reg;
    end

    assign match    = (slot_rd_reg == best_slot_reg);
    assign out_busy = out_valid_reg && out_stall;
    assign out_load = (state_reg == ST_ECHK) && match && !out_busy;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DASN)
        begin
            col_mem[idx_reg[IDX_W-1:0]]  <= c_col[0];
            slot_mem[idx_reg[IDX_W-1:0]] <= best_slot_reg;
        end
        col_rd_reg  <= col_mem[scan_reg];
        slot_rd_reg <= slot_mem[scan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= PC_W'(1);
        end
        else if (cfg_valid)
        begin
            part_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            emit_cnt_reg   <= '0;
            scan_reg       <= '0;
            j_reg          <= '0;
            round_reg      <= '0;
            done_reg       <= '0;
            served_reg     <= '0;
            picked_reg     <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < MAX_PARTITIONS; k++)
            begin
                sum_reg[k]  <= '0;
                size_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_LOAD:
                begin
                    cnt_reg <= cnt_next;
                    if (in_accept && final_column)
                    begin
                        for (int k = 0; k < MAX_PARTITIONS; k++)
                        begin
                            sum_reg[k]  <= '0;
                            size_reg[k] <= '0;
                        end
                        served_reg     <= '0;
                        picked_reg     <= '0;
                        round_reg      <= '0;
                        idx_reg        <= '0;
                        j_reg          <= '0;
                        emit_cnt_reg   <= '0;
                        best_valid_reg <= 1'b0;
                        state_reg      <= ST_DSEL;
                    end
                end
                ST_DSEL, ST_ESEL:
                begin
                    if (cand && (!best_valid_reg || key_less))
                    begin
                        best_valid_reg <= 1'b1;
                        best_slot_reg  <= j_reg;
                        best_sum_reg   <= sum_reg[j_reg];
                        best_size_reg  <= size_reg[j_reg];
                        best_pri_reg   <= pri_j;
                    end
                    if (j_last)
                    begin
                        j_reg     <= '0;
                        scan_reg  <= '0;
                        state_reg <= (state_reg == ST_DSEL) ? ST_DASN : ST_ERD;
                    end
                    else
                    begin
                        j_reg <= j_reg + SLOT_W'(1);
                    end
                end
                ST_DASN:
                begin
                    sum_reg[best_slot_reg]  <= sum_reg[best_slot_reg] +
                                               SUM_W'(c_score[0]);
                    size_reg[best_slot_reg] <= size_reg[best_slot_reg] + SIZE_W'(1);
                    idx_reg        <= idx_reg + LC_W'(1);
                    best_valid_reg <= 1'b0;
                    if (idx_reg + LC_W'(1) == cnt_reg)
                    begin
                        served_reg[best_slot_reg] <= 1'b1;
                        picked_reg                <= '0;
                        done_reg                  <= '0;
                        emit_cnt_reg              <= '0;
                        state_reg                 <= ST_ESEL;
                    end
                    else if (round_reg + PCNT_W'(1) == p_eff)
                    begin
                        served_reg <= '0;
                        picked_reg <= '0;
                        round_reg  <= '0;
                        state_reg  <= ST_DSEL;
                    end
                    else
                    begin
                        served_reg[best_slot_reg] <= 1'b1;
                        picked_reg[best_slot_reg] <= 1'b1;
                        round_reg                 <= round_reg + PCNT_W'(1);
                        state_reg                 <= ST_DSEL;
                    end
                end
                ST_ERD:
                begin
                    picked_reg[best_slot_reg] <= 1'b1;
                    state_reg                 <= ST_ECHK;
                end
                ST_ECHK:
                begin
                    if (!(match && out_busy))
                    begin
                        if (match)
                            emit_cnt_reg <= emit_cnt_reg + LC_W'(1);
                        if (LC_W'(scan_reg) + LC_W'(1) == cnt_reg)
                        begin
                            done_reg       <= done_reg + PCNT_W'(1);
                            best_valid_reg <= 1'b0;
                            if (done_reg + PCNT_W'(1) == p_eff)
                            begin
                                cnt_reg   <= '0;
                                state_reg <= ST_LOAD;
                            end
                            else
                            begin
                                state_reg <= ST_ESEL;
                            end
                        end
                        else
                        begin
                            scan_reg  <= scan_reg + IDX_W'(1);
                            state_reg <= ST_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg  <= col_rd_reg;
            out_last_reg <= (emit_cnt_reg + LC_W'(1) == cnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign mapped_column = out_col_reg;
    assign last_entry    = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(MAX_COLUMNS))
        else $error("loaded count beyond capacity");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (emit_cnt_reg <= cnt_reg))
        else $error("more items emitted than loaded");

    a_assign_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DASN) |-> best_valid_reg)
        else $error("column dealt without a selected partition");

endmodule

>>> tb/tb_balanced_column_partition_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balanced_column_partition_mapper_top
// Loads column sets with random scores under several partition counts,
// predicts the sort, round dealing and emission order, and checks every
// mapped column against it while the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_balanced_column_partition_mapper_top;
    import bcpm_pkg::*;

    localparam int NCOL = 64;
    localparam int NPART = 16;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [COL_W-1:0]   col;
        logic               fin;
        logic               typed;
        logic [COL_W-1:0]   exp_col;
    } stim_row_t;

    typedef struct {
        logic [COL_W-1:0] col;
        logic             last;
    } mapping_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [PC_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [SCORE_W-1:0] score_value;
    logic [COL_W-1:0] column_id;
    logic final_column;
    logic out_valid;
    logic out_stall;
    logic [COL_W-1:0] mapped_column;
    logic last_entry;

    // predictor state
    logic [SCORE_W-1:0] held_score [NCOL];
    logic [COL_W-1:0]   held_col [NCOL];
    int                 held_count;
    logic [SUM_W-1:0]   part_sum [NPART];
    int                 part_size [NPART];
    int                 slot_of [NCOL];
    logic [PC_W-1:0]    part_cfg;

    mapping_t expected_map [$];
    stim_row_t directed [$];
    int mismatches;
    int failed;
    int long_stall;

    balanced_column_partition_mapper_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .score_value(score_value), .column_id(column_id),
        .final_column(final_column),
        .out_valid(out_valid), .out_stall(out_stall),
        .mapped_column(mapped_column), .last_entry(last_entry)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit slot_less(int a, int b);
        if (part_sum[a] != part_sum[b])
            return part_sum[a] < part_sum[b];
        if (part_size[a] != part_size[b])
            return part_size[a] < part_size[b];
        return a < b;
    endfunction

    function automatic void rank_slots(ref int ord[NPART], input int p);
        int j;
        for (int i = 0; i < p; i++)
        begin
            j = i;
            while (j > 0 && slot_less(i, ord[j-1]))
            begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
    endfunction

    function automatic void predict_mapping(logic [SCORE_W-1:0] sc, logic [COL_W-1:0] c,
                                            logic fin);
        int pos;
        int p;
        int idx;
        int cnt;
        int ord [NPART];
        bit served [NPART];
        mapping_t m;
        if (held_count < NCOL)
        begin
            pos = held_count;
            while (pos > 0 && (sc > held_score[pos-1] ||
                   (sc == held_score[pos-1] && c > held_col[pos-1])))
            begin
                held_score[pos] = held_score[pos-1];
                held_col[pos] = held_col[pos-1];
                pos--;
            end
            held_score[pos] = sc;
            held_col[pos] = c;
            held_count++;
        end
        if (!fin)
            return;
        p = (part_cfg == 0) ? 1 : (part_cfg > NPART ? NPART : part_cfg);
        for (int k = 0; k < NPART; k++)
        begin
            part_sum[k] = '0;
            part_size[k] = 0;
            served[k] = 1'b1;
        end
        idx = 0;
        while (idx < held_count)
        begin
            rank_slots(ord, p);
            for (int k = 0; k < p; k++)
                served[k] = 1'b0;
            for (int k = 0; k < p && idx < held_count; k++)
            begin
                part_sum[ord[k]] += held_score[idx];
                part_size[ord[k]]++;
                slot_of[idx] = ord[k];
                served[ord[k]] = 1'b1;
                idx++;
            end
        end
        rank_slots(ord, p);
        cnt = 0;
        for (int pass = 0; pass < 2; pass++)
            for (int k = 0; k < p; k++)
            begin
                if (served[ord[k]] != (pass == 0))
                    continue;
                for (int i = 0; i < held_count; i++)
                    if (slot_of[i] == ord[k])
                    begin
                        cnt++;
                        m.col = held_col[i];
                        m.last = (cnt == held_count);
                        expected_map = {expected_map, m};
                    end
            end
        held_count = 0;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
    endfunction

    task automatic send_item(logic [SCORE_W-1:0] sc, logic [COL_W-1:0] c, logic fin);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        score_value <= sc;
        column_id <= c;
        final_column <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_mapping(sc, c, fin);
    endtask

    task automatic write_partitions(logic [PC_W-1:0] v);
        in_valid <= 1'b0;
        while (expected_map.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        part_cfg = v;
    endtask

    task automatic send_set(int n);
        int big;
        big = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            send_item(big == 0 ? SCORE_W'($urandom()) : SCORE_W'($urandom_range(0, 15)),
                      COL_W'($urandom()), i == n - 1);
    endtask

    // output side: random stall and compare
    always @(posedge clk)
    begin
        mapping_t m;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_map.size() == 0)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item col=%0d last=%0b", mapped_column, last_entry);
                end
                else
                begin
                    m = expected_map.pop_front();
                    if (m.col !== mapped_column || m.last !== last_entry)
                    begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp col=%0d last=%0b got col=%0d last=%0b",
                                     m.col, m.last, mapped_column, last_entry);
                    end
                end
            end
            if (long_stall > 0)
            begin
                long_stall--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 40) == 0)
            begin
                long_stall = $urandom_range(5, 25);
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        stim_row_t r;
        logic [SCORE_W-1:0] sc;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        score_value = '0;
        column_id = '0;
        final_column = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        failed = 0;
        long_stall = 0;
        held_count = 0;
        part_cfg = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single columns after reset with extremes of the fields, then a four-column set
        directed = '{
            '{24'hFFFFFF, 6'd63, 1'b1, 1'b1, 6'd63},
            '{24'h000000, 6'd0,  1'b1, 1'b1, 6'd0},
            '{24'h000005, 6'd10, 1'b0, 1'b0, 6'd0},
            '{24'h000005, 6'd20, 1'b0, 1'b0, 6'd0},
            '{24'hFFFFFF, 6'd2,  1'b0, 1'b0, 6'd0},
            '{24'h000000, 6'd33, 1'b1, 1'b0, 6'd0}
        };
        foreach (directed[i])
        begin
            r = directed[i];
            send_item(r.score, r.col, r.fin);
            if (r.typed && (expected_map.size() == 0 || expected_map[$].col !== r.exp_col ||
                            expected_map[$].last !== 1'b1))
            begin
                failed = 1;
                $display("directed row %0d: wrong prediction", i);
            end
        end
        // zero count, saturation, fewer columns than partitions, equal keys
        write_partitions(PC_W'(0));
        send_item(24'd7, 6'd1, 1'b0);
        send_item(24'd7, 6'd2, 1'b1);
        write_partitions(PC_W'(31));
        for (int i = 0; i < 5; i++)
            send_item(24'd3, COL_W'(i), i == 4);
        write_partitions(PC_W'(16));
        for (int i = 0; i < 20; i++)
            send_item(SCORE_W'(i % 3), COL_W'(i), i == 19);
        // overflow: more than 64 columns, flag on an ignored item
        write_partitions(PC_W'(3));
        for (int i = 0; i < 66; i++)
            send_item(SCORE_W'($urandom()), COL_W'(i), i == 65);

        for (int ph = 0; ph < 14; ph++)
        begin
            write_partitions(ph == 0 ? PC_W'(1) :
                             (ph == 1 ? PC_W'(16) : PC_W'($urandom_range(0, 31))));
            for (int s = 0; s < 3; s++)
                send_set($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        while (expected_map.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (failed == 0 && mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
